[design/prq_pkg.sv]
// Package: shared sizes, codes and link-store port structs for the ready queue.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int TASK_COUNT  = 32;
  localparam int LEVEL_COUNT = 4;
  localparam int TASK_W      = $clog2(TASK_COUNT);
  localparam int LEVEL_W     = $clog2(LEVEL_COUNT);

  typedef logic [TASK_W-1:0]  task_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_PICK   = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // One write per table per cycle.
  typedef struct packed {
    logic   next_we;
    task_t  next_addr;
    task_t  next_data;
    logic   prev_we;
    task_t  prev_addr;
    task_t  prev_data;
    logic   level_we;
    task_t  level_addr;
    level_t level_data;
  } link_wr_t;

  typedef struct packed {
    task_t  next;
    task_t  prev;
    level_t level;
  } link_rd_t;

endpackage

[design/prq_link_store.sv]
// Link store: per-task successor, predecessor and level tables, registered read.
`timescale 1ns / 1ps

module prq_link_store (
  input  logic              clk,
  input  logic              rd_en,
  input  prq_pkg::task_t    rd_addr,
  output prq_pkg::link_rd_t rd,
  input  prq_pkg::link_wr_t wr
);

  prq_pkg::task_t  next_mem  [prq_pkg::TASK_COUNT];
  prq_pkg::task_t  prev_mem  [prq_pkg::TASK_COUNT];
  prq_pkg::level_t level_mem [prq_pkg::TASK_COUNT];

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
    if (wr.level_we) begin
      level_mem[wr.level_addr] <= wr.level_data;
    end
  end

  // Registered read of all three tables at one task.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.next  <= next_mem[rd_addr];
      rd.prev  <= prev_mem[rd_addr];
      rd.level <= level_mem[rd_addr];
    end
  end

endmodule

[design/priority_ready_queue_unit.sv]
// Top level: multilevel priority ready queue with linked lists in memory.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive func, task_id and prio_level with start high; the
//   command transfers at the rising edge where start is high and busy is low.
//   func selects append at tail, insert at head, remove task, or pick next.
//   Result channel: done is high for exactly one cycle, carrying picked_task,
//   picked_valid and status for that command. The receiver cannot stall;
//   sample the result in the cycle done is high.
// Command sequence
//   Each command runs as a read and then a write: the transfer edge reads the neighbor links
//   of the task from the link store, the next edge writes links back and
//   registers the result. done rises at the edge after the transfer; busy is
//   high only in the cycle between, so the next command can transfer at the
//   edge that ends the done cycle, and no command transfers while one executes.
//   This follows from the single read-then-write pass through the link store.
// Reset
//   rst (synchronous) empties all levels and marks every task unqueued; link
//   tables are not cleared, since they are only read for queued tasks.
// Rejects
//   Enqueue of a queued task or removal of an unqueued task returns status 1
//   and leaves all lists unchanged. A pick on empty levels returns zeros.

module priority_ready_queue_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              func,
  input  prq_pkg::task_t          task_id,
  input  prq_pkg::level_t         prio_level,
  output logic                    done,
  output prq_pkg::task_t          picked_task,
  output logic                    picked_valid,
  output logic                    status
);

  // Control state
  prq_pkg::state_t state, state_next;
  logic [prq_pkg::TASK_COUNT-1:0]  task_queued, task_queued_next;
  logic [prq_pkg::LEVEL_COUNT-1:0] level_nonempty, level_nonempty_next;

  // Level head and tail pointers (payload, valid only while non-empty)
  prq_pkg::task_t level_head [prq_pkg::LEVEL_COUNT];
  prq_pkg::task_t level_tail [prq_pkg::LEVEL_COUNT];
  prq_pkg::task_t level_head_next [prq_pkg::LEVEL_COUNT];
  prq_pkg::task_t level_tail_next [prq_pkg::LEVEL_COUNT];

  // Command held across the execute cycle
  prq_pkg::func_t  cmd_func, cmd_func_next;
  prq_pkg::task_t  cmd_task, cmd_task_next;
  prq_pkg::level_t cmd_level, cmd_level_next;
  logic            cmd_ok, cmd_ok_next;

  // Result registers
  logic           done_next;
  prq_pkg::task_t picked_task_next;
  logic           picked_valid_next;
  logic           status_next;

  // Link store ports
  logic              rd_en;
  prq_pkg::task_t    rd_addr;
  prq_pkg::link_rd_t rd;
  prq_pkg::link_wr_t wr;

  // Pick selection
  prq_pkg::level_t pick_level;
  logic            pick_found;

  // Unlink helpers
  prq_pkg::level_t ul_level;
  logic            ul_first;
  logic            ul_last;

  prq_pkg::func_t in_func;

  assign in_func = prq_pkg::func_t'(func);
  assign busy    = (state == prq_pkg::ST_EXEC);

  prq_link_store u_link_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr      (wr)
  );

  // Highest-priority non-empty level: lowest index wins.
  always_comb begin
    pick_level = '0;
    for (int i = prq_pkg::LEVEL_COUNT - 1; i >= 0; i--) begin
      if (level_nonempty[i]) begin
        pick_level = prq_pkg::level_t'(i);
      end
    end
    pick_found = |level_nonempty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= prq_pkg::ST_IDLE;
      task_queued    <= '0;
      level_nonempty <= '0;
      done           <= 1'b0;
    end else begin
      state          <= state_next;
      task_queued    <= task_queued_next;
      level_nonempty <= level_nonempty_next;
      done           <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    level_head   <= level_head_next;
    level_tail   <= level_tail_next;
    cmd_func     <= cmd_func_next;
    cmd_task     <= cmd_task_next;
    cmd_level    <= cmd_level_next;
    cmd_ok       <= cmd_ok_next;
    picked_task  <= picked_task_next;
    picked_valid <= picked_valid_next;
    status       <= status_next;
  end

  // Sequencer: IDLE takes a command and reads the links, EXEC writes back.
  always_comb begin
    state_next          = state;
    task_queued_next    = task_queued;
    level_nonempty_next = level_nonempty;
    level_head_next     = level_head;
    level_tail_next     = level_tail;
    cmd_func_next       = cmd_func;
    cmd_task_next       = cmd_task;
    cmd_level_next      = cmd_level;
    cmd_ok_next         = cmd_ok;
    done_next           = 1'b0;
    picked_task_next    = picked_task;
    picked_valid_next   = picked_valid;
    status_next         = status;
    rd_en               = 1'b0;
    rd_addr             = task_id;
    wr                  = '0;
    ul_level            = (cmd_func == prq_pkg::FUNC_PICK) ? cmd_level : rd.level;
    ul_first            = (level_head[ul_level] == cmd_task);
    ul_last             = (level_tail[ul_level] == cmd_task);

    unique case (state)
      prq_pkg::ST_IDLE: begin
        if (start) begin
          rd_en          = 1'b1;
          cmd_func_next  = in_func;
          cmd_level_next = prio_level;
          cmd_task_next  = task_id;
          unique case (in_func)
            prq_pkg::FUNC_APPEND,
            prq_pkg::FUNC_INSERT: cmd_ok_next = !task_queued[task_id];
            prq_pkg::FUNC_REMOVE: cmd_ok_next = task_queued[task_id];
            prq_pkg::FUNC_PICK: begin
              // Redirect the read to the head of the chosen level.
              cmd_ok_next    = pick_found;
              cmd_level_next = pick_level;
              cmd_task_next  = level_head[pick_level];
              rd_addr        = level_head[pick_level];
            end
            default: cmd_ok_next = 1'b0;
          endcase
          state_next = prq_pkg::ST_EXEC;
        end
      end

      prq_pkg::ST_EXEC: begin
        done_next         = 1'b1;
        picked_task_next  = '0;
        picked_valid_next = 1'b0;
        status_next       = 1'b0;
        state_next        = prq_pkg::ST_IDLE;

        unique case (cmd_func)
          prq_pkg::FUNC_APPEND: begin
            if (!cmd_ok) begin
              status_next = 1'b1;
            end else begin
              if (level_nonempty[cmd_level]) begin
                // Chain behind the old tail.
                wr.next_we   = 1'b1;
                wr.next_addr = level_tail[cmd_level];
                wr.next_data = cmd_task;
                wr.prev_we   = 1'b1;
                wr.prev_addr = cmd_task;
                wr.prev_data = level_tail[cmd_level];
              end else begin
                level_head_next[cmd_level]     = cmd_task;
                level_nonempty_next[cmd_level] = 1'b1;
              end
              level_tail_next[cmd_level] = cmd_task;
              wr.level_we                = 1'b1;
              wr.level_addr              = cmd_task;
              wr.level_data              = cmd_level;
              task_queued_next[cmd_task] = 1'b1;
            end
          end

          prq_pkg::FUNC_INSERT: begin
            if (!cmd_ok) begin
              status_next = 1'b1;
            end else begin
              if (level_nonempty[cmd_level]) begin
                // Chain ahead of the old head.
                wr.prev_we   = 1'b1;
                wr.prev_addr = level_head[cmd_level];
                wr.prev_data = cmd_task;
                wr.next_we   = 1'b1;
                wr.next_addr = cmd_task;
                wr.next_data = level_head[cmd_level];
              end else begin
                level_tail_next[cmd_level]     = cmd_task;
                level_nonempty_next[cmd_level] = 1'b1;
              end
              level_head_next[cmd_level] = cmd_task;
              wr.level_we                = 1'b1;
              wr.level_addr              = cmd_task;
              wr.level_data              = cmd_level;
              task_queued_next[cmd_task] = 1'b1;
            end
          end

          prq_pkg::FUNC_REMOVE,
          prq_pkg::FUNC_PICK: begin
            if (!cmd_ok) begin
              status_next = (cmd_func == prq_pkg::FUNC_REMOVE);
            end else begin
              if (cmd_func == prq_pkg::FUNC_PICK) begin
                picked_task_next  = cmd_task;
                picked_valid_next = 1'b1;
              end
              task_queued_next[cmd_task] = 1'b0;
              // Head's predecessor and tail's successor are never read,
              // so drop those writes.
              priority if (ul_first && ul_last) begin
                level_nonempty_next[ul_level] = 1'b0;
              end else if (ul_first) begin
                level_head_next[ul_level] = rd.next;
              end else if (ul_last) begin
                level_tail_next[ul_level] = rd.prev;
              end else begin
                wr.next_we   = 1'b1;
                wr.next_addr = rd.prev;
                wr.next_data = rd.next;
                wr.prev_we   = 1'b1;
                wr.prev_addr = rd.next;
                wr.prev_data = rd.prev;
              end
            end
          end

          default: status_next = 1'b0;
        endcase
      end

      default: state_next = prq_pkg::ST_IDLE;
    endcase
  end

endmodule
